// ===== design/hmf_pkg.sv =====
// Package for the HTTP message framer: byte class beat, phase codes and the
// Content-Length key text. No dependencies; every module of the framer imports it.
package hmf_pkg;

   localparam logic [7:0] ASCII_LF    = 8'h0A;
   localparam logic [7:0] ASCII_CR    = 8'h0D;
   localparam logic [7:0] ASCII_SPACE = 8'h20;
   localparam logic [7:0] ASCII_ZERO  = 8'h30;

   localparam int unsigned KEY_LEN = 16;
   localparam logic [4:0] KEY_LEN_CODE = 5'd16;
   localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;
   localparam logic [31:0] MAX_BYTES_RESET = 32'd65536;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_BITS = 1;
   localparam int unsigned QUEUE_COUNT_BITS = 2;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_BODY    = 3'd1,
      PH_DONE    = 3'd2,
      PH_BADCHAR = 3'd3,
      PH_TOOLONG = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      VP_SEARCH = 3'd0,
      VP_SPACES = 3'd1,
      VP_DIGITS = 3'd2,
      VP_TRAIL  = 3'd3,
      VP_CLOSED = 3'd4
   } value_phase_type;

   // One received byte together with its classification.
   typedef struct packed {
      logic [7:0] data;
      logic       is_bad;
      logic       is_cr;
      logic       is_lf;
      logic       is_space;
      logic       is_digit;
      logic [3:0] digit;
   } byte_class_type;

   // Characters of "Content-Length: ".
   function automatic logic [7:0] key_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h43; // C
         4'd1:    c = 8'h6F; // o
         4'd2:    c = 8'h6E; // n
         4'd3:    c = 8'h74; // t
         4'd4:    c = 8'h65; // e
         4'd5:    c = 8'h6E; // n
         4'd6:    c = 8'h74; // t
         4'd7:    c = 8'h2D; // -
         4'd8:    c = 8'h4C; // L
         4'd9:    c = 8'h65; // e
         4'd10:   c = 8'h6E; // n
         4'd11:   c = 8'h67; // g
         4'd12:   c = 8'h74; // t
         4'd13:   c = 8'h68; // h
         4'd14:   c = 8'h3A; // :
         4'd15:   c = 8'h20; // space
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

// ===== design/hmf_front.sv =====
// Front end of the HTTP message framer: accepts request beats and classifies each byte.
// Depends on hmf_pkg; feeds hmf_queue.
module hmf_front (
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_data_byte,
   output logic                    push_valid,
   input  logic                    push_ready,
   output hmf_pkg::byte_class_type push_data
);
   import hmf_pkg::*;

   logic [7:0] b;

   assign b = req_data_byte;
   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   always_comb begin
      push_data.data     = b;
      push_data.is_cr    = (b == ASCII_CR);
      push_data.is_lf    = (b == ASCII_LF);
      push_data.is_space = (b == ASCII_SPACE);
      push_data.is_digit = b inside {[8'h30:8'h39]};
      push_data.digit    = 4'(b - ASCII_ZERO);
      // Control characters below 128, other than CR and LF, are not allowed in a header.
      push_data.is_bad   = !b[7] && !(b inside {[8'h20:8'h7E]}) &&
                           (b != ASCII_CR) && (b != ASCII_LF);
   end

endmodule

// ===== design/hmf_queue.sv =====
// Short queue of classified bytes between the framer's front and back ends.
// Depends on hmf_pkg for the beat type and depth.
module hmf_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  hmf_pkg::byte_class_type push_data,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output hmf_pkg::byte_class_type pop_data
);
   import hmf_pkg::*;

   byte_class_type                entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0]   count_ff, count_in;
   logic                          do_push, do_pop;

   assign push_ready = (count_ff != QUEUE_COUNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/hmf_back.sv =====
// Back end of the HTTP message framer: message state update and the response register.
// Depends on hmf_pkg; takes classified bytes from hmf_queue.
module hmf_back #(
   parameter int unsigned COUNT_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [31:0]             max_bytes,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  hmf_pkg::byte_class_type pop_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_status,
   output logic [31:0]             rsp_header_length,
   output logic [30:0]             rsp_body_length,
   output logic [31:0]             rsp_byte_position
);
   import hmf_pkg::*;

   localparam int unsigned WIDE = (COUNT_BITS > 32) ? COUNT_BITS : 32;
   localparam int unsigned END_BITS = ((COUNT_BITS > 31) ? COUNT_BITS : 31) + 1;

   phase_type             phase_ff, phase_in;
   value_phase_type       vp_ff, vp_in;
   logic [COUNT_BITS-1:0] bc_ff, bc_in;
   logic [COUNT_BITS-1:0] hc_ff, hc_in;
   logic [END_BITS-1:0]   end_ff, end_in;
   logic [15:0]           recent_ff, recent_in;
   logic [4:0]            key_ff, key_in;
   logic [30:0]           accum_ff, accum_in;
   logic [30:0]           found_ff, found_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [2:0]            status_ff;
   logic [31:0]           hlen_ff;
   logic [30:0]           blen_ff;
   logic [31:0]           bpos_ff;

   logic                  pop;
   logic [7:0]            prev_byte, prev2_byte;
   logic                  header_end;
   logic [34:0]           times_ten;
   logic [WIDE-1:0]       bc_wide, hc_wide;

   assign pop       = pop_valid && (!rsp_valid_ff || rsp_ready);
   assign pop_ready = pop;

   always_comb begin
      phase_in   = phase_ff;
      vp_in      = vp_ff;
      bc_in      = bc_ff;
      hc_in      = hc_ff;
      end_in     = end_ff;
      recent_in  = recent_ff;
      key_in     = key_ff;
      accum_in   = accum_ff;
      found_in   = found_ff;
      prev_byte  = '0;
      prev2_byte = '0;
      header_end = 1'b0;
      times_ten  = '0;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;

      if (pop) begin
         rsp_valid_in = 1'b1;
         // A byte after a finished message starts a new one.
         if (phase_ff == PH_DONE) begin
            phase_in  = PH_HEADER;
            vp_in     = VP_SEARCH;
            bc_in     = '0;
            hc_in     = '0;
            end_in    = '0;
            recent_in = '0;
            key_in    = '0;
            accum_in  = '0;
            found_in  = '0;
         end

         if (phase_in == PH_HEADER || phase_in == PH_BODY) begin
            if (bc_in == '1 || WIDE'(bc_in) >= WIDE'(max_bytes)) begin
               phase_in = PH_TOOLONG;
            end else begin
               bc_in = bc_in + 1'b1;
               if (phase_in == PH_HEADER) begin
                  prev_byte  = recent_in[7:0];
                  prev2_byte = recent_in[15:8];
                  recent_in  = {recent_in[7:0], pop_data.data};
                  if (pop_data.is_bad) begin
                     phase_in = PH_BADCHAR;
                  end else begin
                     case (vp_in)
                        VP_SEARCH: begin
                           if (!key_in[4] && pop_data.data == key_char(key_in[3:0])) begin
                              key_in = key_in + 1'b1;
                           end else begin
                              key_in = (pop_data.data == key_char(4'd0)) ? 5'd1 : 5'd0;
                           end
                           if (key_in == KEY_LEN_CODE) begin
                              vp_in    = VP_SPACES;
                              accum_in = '0;
                           end
                        end
                        VP_CLOSED: begin
                        end
                        default: begin
                           if (pop_data.is_lf && prev_byte == ASCII_CR) begin
                              found_in = accum_in;
                              vp_in    = VP_CLOSED;
                           end else if (vp_in == VP_SPACES && pop_data.is_space) begin
                              vp_in = VP_SPACES;
                           end else if ((vp_in == VP_SPACES || vp_in == VP_DIGITS) &&
                                        pop_data.is_digit) begin
                              times_ten = ({4'b0, accum_in} << 3) + ({4'b0, accum_in} << 1) +
                                          35'(pop_data.digit);
                              accum_in = (times_ten > 35'(LEN_MAX)) ? LEN_MAX :
                                         times_ten[30:0];
                              vp_in    = VP_DIGITS;
                           end else begin
                              vp_in = VP_TRAIL;
                           end
                        end
                     endcase
                     if (pop_data.is_lf && (prev_byte == ASCII_LF ||
                         (prev_byte == ASCII_CR && prev2_byte == ASCII_LF))) begin
                        header_end = 1'b1;
                        hc_in      = bc_in;
                        end_in     = END_BITS'(bc_in) + END_BITS'(found_in);
                        phase_in   = PH_BODY;
                     end
                  end
               end
               if (phase_in == PH_BODY) begin
                  if (header_end) begin
                     if (found_in == '0) begin
                        phase_in = PH_DONE;
                     end
                  end else if (END_BITS'(bc_in) == end_ff) begin
                     phase_in = PH_DONE;
                  end
               end
            end
         end
      end
   end

   assign bc_wide = WIDE'(bc_in);
   assign hc_wide = WIDE'(hc_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         vp_ff        <= VP_SEARCH;
         bc_ff        <= '0;
         hc_ff        <= '0;
         end_ff       <= '0;
         recent_ff    <= '0;
         key_ff       <= '0;
         accum_ff     <= '0;
         found_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         vp_ff        <= vp_in;
         bc_ff        <= bc_in;
         hc_ff        <= hc_in;
         end_ff       <= end_in;
         recent_ff    <= recent_in;
         key_ff       <= key_in;
         accum_ff     <= accum_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         status_ff <= phase_in;
         hlen_ff   <= hc_wide[31:0];
         blen_ff   <= found_in;
         bpos_ff   <= bc_wide[31:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_header_length = hlen_ff;
   assign rsp_body_length   = blen_ff;
   assign rsp_byte_position = bpos_ff;

endmodule

// ===== design/http_message_framer.sv =====
// HTTP message framer with Content-Length framing: one status beat per received byte.
// Instantiates hmf_front, hmf_queue and hmf_back; depends on hmf_pkg.
//
// Each request beat carries one received byte and yields exactly one response beat
// that reports the message phase (in header, in body, complete, bad character, too
// long), the header length once the blank line is seen, the committed Content-Length
// value and the byte position within the current message. The block sustains one byte
// per clock while the response side is not stalled: the front end classifies a byte
// and writes it into a two-entry queue in the cycle it is accepted, and the back end
// updates the message state and loads the response register together, so the per-byte
// state update in the back end sets the rate. A byte's response is registered: the byte
// is held in a queue entry, then the back end loads the response register as it pops it.
// The response register and the queue let the request side keep taking bytes while a
// finished response waits to be taken. Bad-character and too-long errors are sticky
// until reset; after a message completes, the next byte starts a new message. The
// max_bytes limit (reset value 65536) is written through csr_wr_en and csr_wr_data
// and should only change while the block is idle.
module http_message_framer #(
   parameter int unsigned COUNT_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_header_length,
   output logic [30:0] rsp_body_length,
   output logic [31:0] rsp_byte_position,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import hmf_pkg::*;

   // Message size limit; a write takes effect at the clock edge that carries it.
   logic [31:0]    max_bytes_ff;

   // Classified bytes travel from the front end through the queue to the back end.
   logic           push_valid, push_ready;
   byte_class_type push_data;
   logic           pop_valid, pop_ready;
   byte_class_type pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_bytes_ff <= MAX_BYTES_RESET;
      end else if (csr_wr_en) begin
         max_bytes_ff <= csr_wr_data;
      end
   end

   hmf_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_data     (push_data)
   );

   hmf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // The back end owns the message state machine and the response register.
   hmf_back #(
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .max_bytes         (max_bytes_ff),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_data          (pop_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_header_length (rsp_header_length),
      .rsp_body_length   (rsp_body_length),
      .rsp_byte_position (rsp_byte_position)
   );

endmodule
